@@ design/segment_intersection_test_assert.svh @@
// Assertion macros for the segment intersection test.
// Clock is clk, reset is rst_n (active low), both taken from the using scope.
`ifndef SEGMENT_INTERSECTION_TEST_ASSERT_SVH
`define SEGMENT_INTERSECTION_TEST_ASSERT_SVH

`ifndef SYNTHESIS

`define SIT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define SIT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SIT_ASSERT(label, prop, msg)

`define SIT_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

@@ design/sit_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sit_pkg;

    localparam int COORD_BITS = 16;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int ORI_W      = PROD_W + 1;

    localparam int IN_FIELDS  = 8;
    localparam int S_TDATA_W  = ((IN_FIELDS * COORD_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W  = 8;

    // load strobes for the three registered stages of an orientation unit
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
    } sit_adv_t;

    // orientation flags: sign of the cross product, and collinear-inside-box
    typedef struct packed {
        logic pos;
        logic neg;
        logic on_seg;
    } sit_ori_t;

endpackage

`default_nettype wire

@@ design/segment_intersection_test.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Segment intersection test, streaming.
// Input beat (s_axis): two segments AB and CD as eight signed coordinates,
// a_x in the lowest bits up to d_y. Output beat (m_axis): one bit,
// intersects, in bit 0; high when the segments cross, touch or overlap.
// Every input beat gives exactly one output beat, in order.
// Registered stages from input accept to m_axis_tvalid: edge vectors,
// products, cross product signs, final decision register.
// Throughput: one beat per cycle unless the output stalls; four orientation
// units, each with two 17x17 multipliers, work in parallel on every beat.
// Each stage has its own valid bit and loads when it is empty or the next
// stage moves, so bubbles close up. When m_axis_tready is low the result
// holds in the output register and the stages behind fill; s_axis_tready
// drops only once all four stages are full. Nothing is lost or repeated.
// Reset (rst_n low, asynchronous) clears all valid bits; the pipeline is
// empty and s_axis_tready is high right after reset.
`include "segment_intersection_test_assert.svh"

module segment_intersection_test (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y
    input  wire logic [sit_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // intersects, zero pad
    output logic [sit_pkg::M_TDATA_W-1:0]      m_axis_tdata
);
    import sit_pkg::*;

    localparam int CB = COORD_BITS;

    logic signed [CB-1:0] a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y;
    logic       v1_reg, v2_reg, v3_reg, vo_reg;
    logic       rdy1, rdy2, rdy3, rdyo;
    sit_adv_t   adv;
    sit_ori_t   o1, o2, o3, o4;
    logic       hit_reg, hit_next;

    assign a_x = s_axis_tdata[0*CB +: CB];
    assign a_y = s_axis_tdata[1*CB +: CB];
    assign b_x = s_axis_tdata[2*CB +: CB];
    assign b_y = s_axis_tdata[3*CB +: CB];
    assign c_x = s_axis_tdata[4*CB +: CB];
    assign c_y = s_axis_tdata[5*CB +: CB];
    assign d_x = s_axis_tdata[6*CB +: CB];
    assign d_y = s_axis_tdata[7*CB +: CB];

    // a stage may load when empty or when its content moves on
    assign rdyo = !vo_reg || m_axis_tready;
    assign rdy3 = !v3_reg || rdyo;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign adv.ld1 = rdy1 && s_axis_tvalid;
    assign adv.ld2 = rdy2 && v1_reg;
    assign adv.ld3 = rdy3 && v2_reg;

    sit_orient u_ori_abc (
        .clk (clk), .p_x (a_x), .p_y (a_y), .q_x (b_x), .q_y (b_y),
        .r_x (c_x), .r_y (c_y), .adv (adv), .ori (o1)
    );
    sit_orient u_ori_abd (
        .clk (clk), .p_x (a_x), .p_y (a_y), .q_x (b_x), .q_y (b_y),
        .r_x (d_x), .r_y (d_y), .adv (adv), .ori (o2)
    );
    sit_orient u_ori_cda (
        .clk (clk), .p_x (c_x), .p_y (c_y), .q_x (d_x), .q_y (d_y),
        .r_x (a_x), .r_y (a_y), .adv (adv), .ori (o3)
    );
    sit_orient u_ori_cdb (
        .clk (clk), .p_x (c_x), .p_y (c_y), .q_x (d_x), .q_y (d_y),
        .r_x (b_x), .r_y (b_y), .adv (adv), .ori (o4)
    );

    // proper crossing needs strictly opposite sides both ways
    always_comb
    begin
        hit_next = (((o1.pos && o2.neg) || (o1.neg && o2.pos)) &&
                    ((o3.pos && o4.neg) || (o3.neg && o4.pos))) ||
                   o1.on_seg || o2.on_seg || o3.on_seg || o4.on_seg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= s_axis_tvalid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdyo)
            begin
                vo_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdyo && v3_reg)
        begin
            hit_reg <= hit_next;
        end
    end

    assign s_axis_tready = rdy1;
    assign m_axis_tvalid = vo_reg;
    assign m_axis_tdata  = {{(M_TDATA_W-1){1'b0}}, hit_reg};

    `SIT_ASSERT(a_sign_excl, v3_reg |-> !(o1.pos && o1.neg) && !(o3.pos && o3.neg), "orientation both positive and negative")
    `SIT_ASSERT(a_stage3_hold, (v3_reg && !rdyo) |=> v3_reg, "stalled stage 3 beat dropped")
    `SIT_ASSERT(a_accept_lands, (s_axis_tvalid && s_axis_tready) |=> v1_reg, "accepted beat not in stage 1")
    `SIT_ASSERT(a_out_moves, (m_axis_tvalid && m_axis_tready && !v3_reg) |=> !m_axis_tvalid, "output beat repeated")

endmodule

`default_nettype wire

@@ design/sit_orient.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sit_orient (
    input  wire logic                                clk,
    input  wire logic signed [sit_pkg::COORD_BITS-1:0] p_x,
    input  wire logic signed [sit_pkg::COORD_BITS-1:0] p_y,
    input  wire logic signed [sit_pkg::COORD_BITS-1:0] q_x,
    input  wire logic signed [sit_pkg::COORD_BITS-1:0] q_y,
    input  wire logic signed [sit_pkg::COORD_BITS-1:0] r_x,
    input  wire logic signed [sit_pkg::COORD_BITS-1:0] r_y,
    input  wire sit_pkg::sit_adv_t                   adv,
    output sit_pkg::sit_ori_t                        ori
);
    import sit_pkg::*;

    logic signed [DIFF_W-1:0] dqx_reg, dqy_reg, drx_reg, dry_reg;
    logic signed [DIFF_W-1:0] dqx_next, dqy_next, drx_next, dry_next;
    logic                     inbox1_reg, inbox1_next;
    logic signed [PROD_W-1:0] t1_reg, t2_reg, t1_next, t2_next;
    logic                     inbox2_reg;
    logic signed [ORI_W-1:0]  o_next;
    sit_ori_t                 ori_reg, ori_next;
    logic                     in_x, in_y;

    // stage 1: edge vectors and bounding box test of r against pq
    always_comb
    begin
        dqx_next = $signed({q_x[COORD_BITS-1], q_x}) - $signed({p_x[COORD_BITS-1], p_x});
        dqy_next = $signed({q_y[COORD_BITS-1], q_y}) - $signed({p_y[COORD_BITS-1], p_y});
        drx_next = $signed({r_x[COORD_BITS-1], r_x}) - $signed({p_x[COORD_BITS-1], p_x});
        dry_next = $signed({r_y[COORD_BITS-1], r_y}) - $signed({p_y[COORD_BITS-1], p_y});
        in_x = ((r_x >= p_x) && (r_x <= q_x)) || ((r_x >= q_x) && (r_x <= p_x));
        in_y = ((r_y >= p_y) && (r_y <= q_y)) || ((r_y >= q_y) && (r_y <= p_y));
        inbox1_next = in_x && in_y;
    end

    // stage 2: the two partial products
    always_comb
    begin
        t1_next = dqx_reg * dry_reg;
        t2_next = dqy_reg * drx_reg;
    end

    // stage 3: cross product and its sign
    always_comb
    begin
        o_next = $signed({t1_reg[PROD_W-1], t1_reg}) - $signed({t2_reg[PROD_W-1], t2_reg});
        ori_next.pos    = !o_next[ORI_W-1] && (o_next != '0);
        ori_next.neg    = o_next[ORI_W-1];
        ori_next.on_seg = (o_next == '0) && inbox2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv.ld1)
        begin
            dqx_reg    <= dqx_next;
            dqy_reg    <= dqy_next;
            drx_reg    <= drx_next;
            dry_reg    <= dry_next;
            inbox1_reg <= inbox1_next;
        end
        if (adv.ld2)
        begin
            t1_reg     <= t1_next;
            t2_reg     <= t2_next;
            inbox2_reg <= inbox1_reg;
        end
        if (adv.ld3)
        begin
            ori_reg <= ori_next;
        end
    end

    assign ori = ori_reg;

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    import sit_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_PAIRS = 2000;
    localparam int LONG_HOLD    = 120;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct {
        coord_t ax, ay, bx, by, cx, cy, dx, dy;
    } seg_pair_t;

    // Predicts the hit flag for every accepted pair and checks results in order.
    class hit_scoreboard;
        bit expected_hits[$];
        int errors;
        int checked;
        int hits;

        function longint cross3(longint px, longint py, longint qx, longint qy,
                                longint rx, longint ry);
            return (qx - px) * (ry - py) - (qy - py) * (rx - px);
        endfunction

        function bit in_span(longint v, longint e0, longint e1);
            longint lo;
            longint hi;
            lo = (e0 < e1) ? e0 : e1;
            hi = (e0 < e1) ? e1 : e0;
            return (v >= lo) && (v <= hi);
        endfunction

        function bit predict_hit(seg_pair_t p);
            longint ax, ay, bx, by, cx, cy, dx, dy;
            longint o1, o2, o3, o4;
            bit straddle;
            ax = p.ax; ay = p.ay; bx = p.bx; by = p.by;
            cx = p.cx; cy = p.cy; dx = p.dx; dy = p.dy;
            o1 = cross3(ax, ay, bx, by, cx, cy);
            o2 = cross3(ax, ay, bx, by, dx, dy);
            o3 = cross3(cx, cy, dx, dy, ax, ay);
            o4 = cross3(cx, cy, dx, dy, bx, by);
            straddle = ((o1 > 0 && o2 < 0) || (o1 < 0 && o2 > 0)) &&
                       ((o3 > 0 && o4 < 0) || (o3 < 0 && o4 > 0));
            // collinear endpoint inside the other segment's closed box
            return straddle
                || (o1 == 0 && in_span(cx, ax, bx) && in_span(cy, ay, by))
                || (o2 == 0 && in_span(dx, ax, bx) && in_span(dy, ay, by))
                || (o3 == 0 && in_span(ax, cx, dx) && in_span(ay, cy, dy))
                || (o4 == 0 && in_span(bx, cx, dx) && in_span(by, cy, dy));
        endfunction

        function void note_pair(seg_pair_t p);
            expected_hits.push_back(predict_hit(p));
        endfunction

        function void check_result(logic got);
            bit want;
            if (expected_hits.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat, expected none, actual intersects=%b",
                         $time, got);
                return;
            end
            want = expected_hits.pop_front();
            checked++;
            if (want)
                hits++;
            if (got !== want)
            begin
                errors++;
                $display("%0t: intersects mismatch, expected %b, actual %b",
                         $time, want, got);
            end
        endfunction

        function int pending();
            return expected_hits.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_req    = 0;
    int cycle_cnt   = 0;
    int pairs_sent  = 0;

    hit_scoreboard sb = new;

    segment_intersection_test dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic seg_pair_t mk_pair(int ax, int ay, int bx, int by,
                                          int cx, int cy, int dx, int dy);
        seg_pair_t p;
        p.ax = coord_t'(ax); p.ay = coord_t'(ay);
        p.bx = coord_t'(bx); p.by = coord_t'(by);
        p.cx = coord_t'(cx); p.cy = coord_t'(cy);
        p.dx = coord_t'(dx); p.dy = coord_t'(dy);
        return p;
    endfunction

    function automatic int spread(int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    function automatic int extreme_coord();
        int vals[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
        return vals[$urandom_range(6)];
    endfunction

    function automatic seg_pair_t swap_segments(seg_pair_t p);
        seg_pair_t q;
        q = p;
        if ($urandom_range(1))
        begin
            q.ax = p.cx; q.ay = p.cy; q.bx = p.dx; q.by = p.dy;
            q.cx = p.ax; q.cy = p.ay; q.dx = p.bx; q.dy = p.by;
        end
        return q;
    endfunction

    function automatic seg_pair_t rand_pair();
        int kind, px, py, ux, uy, m, j;
        kind = $urandom_range(99);
        px = spread(20000);
        py = spread(20000);
        ux = spread(50);
        uy = spread(50);
        m  = $urandom_range(100, 1);
        j  = $urandom_range(m);
        if (kind < 20)
            return mk_pair($urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, $urandom);
        else if (kind < 45)
            // tiny grid: lots of shared points, collinear and touching cases
            return mk_pair(spread(4), spread(4), spread(4), spread(4),
                           spread(4), spread(4), spread(4), spread(4));
        else if (kind < 60)
            return mk_pair(px + spread(100) * ux, py + spread(100) * uy,
                           px + spread(100) * ux, py + spread(100) * uy,
                           px + spread(100) * ux, py + spread(100) * uy,
                           px + spread(100) * ux, py + spread(100) * uy);
        else if (kind < 72)
            // C placed on AB (or just past it), D anywhere nearby
            return swap_segments(mk_pair(px, py, px + m * ux, py + m * uy,
                                         px + (j + spread(1)) * ux,
                                         py + (j + spread(1)) * uy,
                                         px + spread(300), py + spread(300)));
        else if (kind < 82)
            return swap_segments(mk_pair(px, py, px, py,
                                         px + spread(3) * ux, py + spread(3) * uy,
                                         px + spread(3) * ux, py + spread(3) * uy));
        else if (kind < 92)
            return mk_pair(extreme_coord(), extreme_coord(), extreme_coord(),
                           extreme_coord(), extreme_coord(), extreme_coord(),
                           extreme_coord(), extreme_coord());
        else
            return mk_pair(px, py, px + spread(200), py + spread(200),
                           px + spread(200), py + spread(200),
                           px + spread(200), py + spread(200));
    endfunction

    task automatic send_pair(seg_pair_t p);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        // tdata: a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y from bit 0 up
        s_axis_tdata  <= S_TDATA_W'({p.dy, p.dx, p.cy, p.cx, p.by, p.bx, p.ay, p.ax});
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_pair(p);
        pairs_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic run_directed();
        send_pair(mk_pair(-10, -10, 10, 10, -10, 10, 10, -10));
        send_pair(mk_pair(0, 0, 10, 0, 0, 5, 10, 5));
        send_pair(mk_pair(0, 0, 10, 0, 5, 0, 15, 0));
        send_pair(mk_pair(0, 0, 4, 0, 5, 0, 9, 0));
        send_pair(mk_pair(0, 0, 5, 0, 5, 0, 9, 0));
        send_pair(mk_pair(0, 0, 10, 0, 5, 0, 5, 7));
        send_pair(mk_pair(0, 0, 10, 0, 5, 1, 5, 7));
        send_pair(mk_pair(3, 3, 3, 3, 0, 0, 6, 6));
        send_pair(mk_pair(3, 4, 3, 4, 0, 0, 6, 6));
        send_pair(mk_pair(7, -2, 7, -2, 7, -2, 7, -2));
        send_pair(mk_pair(1, 1, 1, 1, 2, 2, 2, 2));
        send_pair(mk_pair(-32768, -32768, -32768, -32768,
                          -32768, -32768, -32768, -32768));
        send_pair(mk_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_pair(mk_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
        send_pair(mk_pair(-32768, -32768, 32767, 32767, -32768, -32767, 32766, 32767));
        send_pair(mk_pair(-32768, -32767, 32767, 32767, -32768, -32768, 32766, 32767));
        send_pair(mk_pair(0, -5, 0, 5, 0, -1, 0, 1));
        send_pair(mk_pair(32767, -32768, -32768, 32767, 0, 0, -1, -1));
        send_pair(mk_pair(2, 3, 9, 9, 2, 3, 2, 3));
        send_pair(mk_pair(0, 0, 2, 2, 3, 3, 5, 5));
        send_pair(mk_pair(21845, -21846, 21845, -21846, -21846, 21845, -21846, 21845));
        send_pair(mk_pair(-21846, 21845, -21846, 21845, 21845, -21846, 21845, -21846));
    endtask

    // receiver: random backpressure, plus an occasional long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata[0]);
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d beats outstanding",
                     $time, cycle_cnt, sb.pending());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 63 : 0;
            rx_idle_pct = (phase == 0) ? 63 : (phase == 1) ? 9 : 0;
            for (int i = 0; i < RANDOM_PAIRS / 3; i++)
            begin
                if (phase == 2 && i == 100)
                    hold_req = LONG_HOLD;   // output stalls, pipeline backs up
                if (phase == 1 && i == 300)
                    drain();
                send_pair(rand_pair());
            end
        end

        drain();
        repeat (20) @(posedge clk);

        $display("Checked %0d of %0d segment pairs: %0d crossing or touching, %0d apart.",
                 sb.checked, pairs_sent, sb.hits, sb.checked - sb.hits);
        $display("Covered directed corners, random mixes, a %0d-cycle output stall and a drain.",
                 LONG_HOLD);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ segment_intersection_test.f @@
+incdir+design
design/sit_pkg.sv
design/sit_orient.sv
design/segment_intersection_test.sv
dv/tb_top.sv
